>>> sv/sscnt_pkg.sv
// sscnt_pkg: types and constants shared by the substring occurrence counter
// used by sscnt_cell and substring_occurrence_counter; no dependencies
package sscnt_pkg;

    localparam int OP_W    = 2;
    localparam int INDEX_W = 6;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;
    localparam int COUNT_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_TEXT    = 2'd1,
        OP_RESTART = 2'd2
    } sscnt_op_t;

    typedef struct packed {
        sscnt_op_t          op;
        logic [INDEX_W-1:0] pattern_index;
        logic [BYTE_W-1:0]  byte_value;
    } sscnt_in_t;

    typedef struct packed {
        logic               match_here;
        logic [COUNT_W-1:0] match_count;
    } sscnt_out_t;

    // what every cell of the window chain does this cycle
    typedef struct packed {
        logic text;      // new text byte enters, history moves down
        logic shift_up;  // realign one place toward higher cells
        logic shift_dn;  // realign one place toward lower cells
    } sscnt_ctl_t;

endpackage

>>> sv/sscnt_cell.sv
// sscnt_cell: one place of the text window chain, with an optional pattern byte
// and its compare; depends on sscnt_pkg
module sscnt_cell
    import sscnt_pkg::*;
#(
    parameter bit HAS_PAT = 1'b1
)
(
    input  logic              clk,
    input  sscnt_ctl_t        ctl,
    input  logic              inject,
    input  logic [BYTE_W-1:0] new_byte,
    input  logic [BYTE_W-1:0] from_above,
    input  logic [BYTE_W-1:0] from_below,
    input  logic              pat_we,
    input  logic [BYTE_W-1:0] pat_data,
    output logic [BYTE_W-1:0] hist,
    output logic              eq
);

    logic [BYTE_W-1:0] hist_reg;
    logic [BYTE_W-1:0] hist_next;
    logic [BYTE_W-1:0] text_val;

    // value this place takes when a text byte arrives
    assign text_val = inject ? new_byte : from_above;

    always_comb
    begin
        hist_next = hist_reg;
        if (ctl.text)
        begin
            hist_next = text_val;
        end
        else if (ctl.shift_up)
        begin
            hist_next = from_below;
        end
        else if (ctl.shift_dn)
        begin
            hist_next = from_above;
        end
    end

    always_ff @(posedge clk)
    begin
        hist_reg <= hist_next;
    end

    assign hist = hist_reg;

    generate
        if (HAS_PAT)
        begin : g_pat
            logic [BYTE_W-1:0] pat_reg;

            always_ff @(posedge clk)
            begin
                if (pat_we)
                begin
                    pat_reg <= pat_data;
                end
            end

            // compare against the window as it stands after this text byte
            assign eq = (text_val == pat_reg);
        end
        else
        begin : g_nopat
            assign eq = 1'b0;
        end
    endgenerate

endmodule

>>> sv/substring_occurrence_counter.sv
// a result word is registered when its input word is taken
// throughput: one word per cycle while in_ready is high; the full window compare runs in the cell row
// a write to pattern_length realigns the window one place per cycle from the next cycle,
// holding in_ready low until the window is aligned; a zero length aligns like length one
// reset: length 1, count and bytes seen cleared; pattern bytes undefined until loaded
module substring_occurrence_counter
    import sscnt_pkg::*;
#(
    parameter int MAX_PATTERN = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sscnt_in_t        in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output sscnt_out_t       out_data,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data
);

    localparam int NCELL = 2 * MAX_PATTERN;
    localparam int AW    = $clog2(MAX_PATTERN + 1);

    logic [LEN_W-1:0]   len_reg;
    logic [AW-1:0]      align_reg;
    logic [AW-1:0]      align_next;
    logic [AW-1:0]      seen_reg;
    logic [AW-1:0]      seen_next;
    logic [AW-1:0]      seen_inc;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    logic               out_valid_reg;
    sscnt_out_t         out_data_reg;
    sscnt_out_t         result;

    logic [AW-1:0]      len_eff;
    logic [AW-1:0]      tgt;
    logic               busy;
    logic               acc;
    logic               hit;
    sscnt_ctl_t         ctl;

    logic [BYTE_W-1:0]      hist [NCELL];
    logic [NCELL-1:0]       eq_all;
    logic [MAX_PATTERN-1:0] eq;
    logic [MAX_PATTERN-1:0] active;

    // lengths above the window use the whole window
    always_comb
    begin
        if (int'(len_reg) > MAX_PATTERN)
        begin
            len_eff = AW'(MAX_PATTERN);
        end
        else
        begin
            len_eff = AW'(len_reg);
        end
        tgt = (len_reg == '0) ? AW'(1) : len_eff;
    end

    assign busy     = (align_reg != tgt);
    assign in_ready = !busy && (!out_valid_reg || out_ready);
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        ctl.text     = acc && (in_data.op == OP_TEXT);
        ctl.shift_up = busy && (align_reg < tgt);
        ctl.shift_dn = busy && (align_reg > tgt);
    end

    always_comb
    begin
        align_next = align_reg;
        if (ctl.shift_up)
        begin
            align_next = align_reg + AW'(1);
        end
        else if (ctl.shift_dn)
        begin
            align_next = align_reg - AW'(1);
        end
    end

    // newest byte sits at cell MAX_PATTERN + align - 1, older bytes below it
    genvar p;
    generate
        for (p = 0; p < NCELL; p++)
        begin : g_cell
            logic [BYTE_W-1:0] above;
            logic [BYTE_W-1:0] below;
            logic              inject;
            logic              pat_we;

            if (p == NCELL - 1)
            begin : g_top
                assign above = '0;
            end
            else
            begin : g_mid_a
                assign above = hist[p+1];
            end

            if (p == 0)
            begin : g_bot
                assign below = '0;
            end
            else
            begin : g_mid_b
                assign below = hist[p-1];
            end

            assign inject = (int'(align_reg) + MAX_PATTERN - 1 == p);

            if (p >= MAX_PATTERN)
            begin : g_ld
                assign pat_we = acc && (in_data.op == OP_LOAD)
                                && (int'(in_data.pattern_index) == p - MAX_PATTERN);
            end
            else
            begin : g_no_ld
                assign pat_we = 1'b0;
            end

            sscnt_cell #(
                .HAS_PAT (p >= MAX_PATTERN)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .inject     (inject),
                .new_byte   (in_data.byte_value),
                .from_above (above),
                .from_below (below),
                .pat_we     (pat_we),
                .pat_data   (in_data.byte_value),
                .hist       (hist[p]),
                .eq         (eq_all[p])
            );
        end

        for (p = 0; p < MAX_PATTERN; p++)
        begin : g_act
            assign eq[p]     = eq_all[MAX_PATTERN + p];
            assign active[p] = (p < int'(len_eff));
        end
    endgenerate

    assign seen_inc  = (int'(seen_reg) == MAX_PATTERN) ? seen_reg : seen_reg + AW'(1);
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + COUNT_W'(1);
    assign hit       = (len_reg != '0) && (seen_inc >= len_eff) && (&(eq | ~active));

    always_comb
    begin
        seen_next          = seen_reg;
        count_next         = count_reg;
        result.match_here  = 1'b0;
        result.match_count = count_reg;
        case (in_data.op)
            OP_LOAD:
            begin
                result.match_count = count_reg;
            end
            OP_TEXT:
            begin
                seen_next = seen_inc;
                if (hit)
                begin
                    count_next         = count_inc;
                    result.match_here  = 1'b1;
                    result.match_count = count_inc;
                end
            end
            OP_RESTART:
            begin
                seen_next          = '0;
                count_next         = '0;
                result.match_count = '0;
            end
            default:
            begin
                result.match_count = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_W'(1);
            align_reg     <= AW'(1);
            seen_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end
            align_reg <= align_next;
            if (acc)
            begin
                seen_reg      <= seen_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result word holds until taken
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
